[src/pbc_pkg.sv]
// Shared types and codes for the clock-replacement page buffer pool.
// Used by pbc_ctrl, pbc_datapath and the top level.
package pbc_pkg;

  localparam int DEF_POOL_FRAMES = 64;
  localparam int DEF_PIN_BITS    = 8;
  localparam int PAGE_W          = 32;
  localparam int SWEEP_PASSES    = 2;

  // request codes
  typedef enum logic [2:0] {
    REQ_FETCH  = 3'd0,
    REQ_NEW    = 3'd1,
    REQ_UNPIN  = 3'd2,
    REQ_FLUSH  = 3'd3,
    REQ_DELETE = 3'd4
  } req_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_FRAME   = 3'd1,
    ST_ABSENT     = 3'd2,
    ST_NOT_PINNED = 3'd3,
    ST_PINNED     = 3'd4
  } st_t;

  // disk command codes
  typedef enum logic [1:0] {
    DK_NONE    = 2'd0,
    DK_READ    = 2'd1,
    DK_WRITE   = 2'd2,
    DK_DEALLOC = 2'd3
  } dk_t;

  // controller states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_FQ_TAKE,
    S_SWEEP_INIT,
    S_SWEEP,
    S_EMIT_WB,
    S_FINISH
  } state_t;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_SCAN,
    CMD_FQ_TAKE,
    CMD_SWEEP_INIT,
    CMD_SWEEP,
    CMD_EMIT_WB,
    CMD_FINISH
  } dp_cmd_t;

  // datapath status toward the controller
  typedef struct packed {
    logic clear_done;
    logic scan_done;
    logic sweep_done;
    logic hit;
    logic got;
    logic wb;
    logic free_avail;
    logic out_free;
    logic is_alloc;
  } dp_stat_t;

endpackage

[src/page_buffer_pool_clock_replacement.sv]
// Top level of the page buffer pool with clock (second chance) replacement.
// Instantiates pbc_ctrl and pbc_datapath; depends on pbc_pkg.
//
// Requests enter on the s_axis channel: one transaction carries a request
// type, a page id and the dirty mark of an unpin. Results leave on m_axis,
// one or two per request; tlast marks the final one. A write back of an
// evicted dirty page comes first, with tlast low.
// A request is handled alone. Every request looks up its page by reading
// the frame table one frame a cycle; its result is then registered, and
// the next request can be accepted in the cycle after that.
// A miss takes a frame from the free queue when one is there. With no free
// frame the clock sweep reads one frame a cycle from the hand, over at most
// SWEEP_PASSES passes of the table; a dirty victim adds its write back.
// The frame table's single read port sets this pace.
// After reset the free queue is filled with frames 0 to POOL_FRAMES-1, one
// entry a cycle; s_axis_tready stays low meanwhile.
// Results sit in an output register: a new request is accepted while a
// result waits, but the next result is held back until m_axis_tready.
module page_buffer_pool_clock_replacement #(
  parameter int POOL_FRAMES = pbc_pkg::DEF_POOL_FRAMES,
  parameter int PIN_BITS    = pbc_pkg::DEF_PIN_BITS,
  localparam int AW = $clog2(POOL_FRAMES),
  localparam int TW = $clog2(POOL_FRAMES + 1),
  localparam int DW = 3 + AW + 2 + 32 + TW,
  localparam int OW = ((DW + 7) / 8) * 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // req_type[2:0], page_number[34:3], dirty mark[35], zero pad
  input  logic [39:0]   s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // status, frame_index, disk_command, disk_page, dirty_total, zero pad
  output logic [OW-1:0] m_axis_tdata,
  output logic          m_axis_tlast
);
  import pbc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic [2:0]    o_status;
  logic [AW-1:0] o_frame;
  logic [1:0]    o_cmd;
  logic [31:0]   o_page;
  logic [TW-1:0] o_total;

  pbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_tvalid (s_axis_tvalid),
    .in_tready (s_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pbc_datapath #(
    .POOL_FRAMES (POOL_FRAMES),
    .PIN_BITS    (PIN_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_req     (s_axis_tdata[2:0]),
    .in_page    (s_axis_tdata[34:3]),
    .in_mark    (s_axis_tdata[35]),
    .out_tready (m_axis_tready),
    .out_tvalid (m_axis_tvalid),
    .out_last   (m_axis_tlast),
    .out_status (o_status),
    .out_frame  (o_frame),
    .out_cmd    (o_cmd),
    .out_page   (o_page),
    .out_total  (o_total)
  );

  // result packing, first field lowest
  assign m_axis_tdata = OW'({o_total, o_page, o_cmd, o_frame, o_status});

  // one request at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another is in progress");

  // a non-final result is always a write back
  a_wb_only_first: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (o_cmd == DK_WRITE))
    else $error("non-final result is not a write back");

  // a lookup hit never also takes a new frame
  a_hit_or_take: assert property (@(posedge clk) disable iff (rst)
    !(stat.hit && stat.got))
    else $error("hit and frame take in the same request");

  // results are only loaded when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_FINISH || cmd == CMD_EMIT_WB) |-> stat.out_free)
    else $error("result register overwritten");

endmodule

[src/pbc_datapath.sv]
// Datapath of the buffer pool: frame table memory, valid bits, free queue,
// clock hand, dirty tally and the result register. Depends on pbc_pkg.
module pbc_datapath #(
  parameter int POOL_FRAMES = pbc_pkg::DEF_POOL_FRAMES,
  parameter int PIN_BITS    = pbc_pkg::DEF_PIN_BITS,
  localparam int AW = $clog2(POOL_FRAMES),
  localparam int TW = $clog2(POOL_FRAMES + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pbc_pkg::dp_cmd_t      cmd,
  output pbc_pkg::dp_stat_t     stat,
  input  logic [2:0]            in_req,
  input  logic [31:0]           in_page,
  input  logic                  in_mark,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic                  out_last,
  output logic [2:0]            out_status,
  output logic [AW-1:0]         out_frame,
  output logic [1:0]            out_cmd,
  output logic [31:0]           out_page,
  output logic [TW-1:0]         out_total
);
  import pbc_pkg::*;

  localparam int EW = PAGE_W + PIN_BITS + 2;
  localparam int CW = $clog2(SWEEP_PASSES * POOL_FRAMES + 2);
  localparam int LW = $clog2(POOL_FRAMES + 1);

  // entry layout: {page, pins, dirty, referenced}
  logic [EW-1:0]        ent_mem [POOL_FRAMES];
  logic [AW-1:0]        fq_mem  [POOL_FRAMES];
  logic [POOL_FRAMES-1:0] valid;

  logic [2:0]    req;
  logic [31:0]   req_page;
  logic          mark;
  logic [AW-1:0] head;
  logic [LW-1:0] level;
  logic [AW-1:0] hand;
  logic [TW-1:0] tally;
  logic [CW-1:0] cnt;
  logic [AW-1:0] addr;
  logic [EW-1:0] rd_data;
  logic [AW-1:0] rd_idx;
  logic          rd_live;
  logic [AW-1:0] fq_rd;
  logic          hit;
  logic [AW-1:0] f;
  logic [EW-1:0] e;
  logic          got;
  logic [AW-1:0] g;
  logic          wb;
  logic [31:0]   wb_page;

  logic [AW-1:0] addr_inc;
  logic [AW-1:0] head_inc;
  logic [AW+1:0] push_sum;
  logic [AW-1:0] push_slot;
  logic          issue;
  logic          sc_hit;
  logic          sw_eval;
  logic          sw_ok;
  logic          sw_clr;
  logic          sw_take;
  logic [TW-1:0] tally_dec;

  // finish-step results
  logic [2:0]    f_st;
  logic [AW-1:0] f_fr;
  logic [1:0]    f_dc;
  logic [31:0]   f_dp;
  logic          f_we;
  logic [AW-1:0] f_wa;
  logic [EW-1:0] f_wd;
  logic          f_vset;
  logic          f_vclr;
  logic          f_push;
  logic [TW-1:0] tally_nx;

  logic          m_we;
  logic [AW-1:0] m_wa;
  logic [EW-1:0] m_wd;

  logic [PIN_BITS-1:0] e_pins;
  logic [PIN_BITS-1:0] rd_pins;

  assign e_pins  = e[PIN_BITS+1:2];
  assign rd_pins = rd_data[PIN_BITS+1:2];

  // wrapping index arithmetic
  assign addr_inc  = (addr == AW'(POOL_FRAMES - 1)) ? '0 : addr + 1'b1;
  assign head_inc  = (head == AW'(POOL_FRAMES - 1)) ? '0 : head + 1'b1;
  assign push_sum  = (AW+2)'(head) + (AW+2)'(level);
  assign push_slot = (push_sum >= (AW+2)'(POOL_FRAMES)) ?
                     AW'(push_sum - (AW+2)'(POOL_FRAMES)) : AW'(push_sum);
  assign tally_dec = (tally != '0) ? tally - 1'b1 : tally;

  // read issue and evaluation during lookup and sweep
  always_comb begin
    issue = 1'b0;
    if (cmd == CMD_SCAN)  issue = (cnt < CW'(POOL_FRAMES));
    if (cmd == CMD_SWEEP) issue = (cnt < CW'(SWEEP_PASSES * POOL_FRAMES)) && !got;
  end

  assign sc_hit  = (cmd == CMD_SCAN) && rd_live && valid[rd_idx] &&
                   (rd_data[EW-1 -: PAGE_W] == req_page);
  assign sw_eval = (cmd == CMD_SWEEP) && rd_live && !got;
  assign sw_ok   = valid[rd_idx] && (rd_pins == '0);
  assign sw_clr  = sw_eval && sw_ok && rd_data[0];
  assign sw_take = sw_eval && sw_ok && !rd_data[0];

  // request completion: result fields and state updates
  always_comb begin
    f_st     = ST_OK;
    f_fr     = '0;
    f_dc     = DK_NONE;
    f_dp     = '0;
    f_we     = 1'b0;
    f_wa     = f;
    f_wd     = e;
    f_vset   = 1'b0;
    f_vclr   = 1'b0;
    f_push   = 1'b0;
    tally_nx = tally;
    case (req) inside
      REQ_FETCH, REQ_NEW: begin
        if (hit) begin
          f_we = 1'b1;
          f_wd[PIN_BITS+1:2] = (e_pins == '1) ? e_pins : e_pins + 1'b1;
          f_wd[0] = 1'b1;
          f_fr = f;
        end else if (!got) begin
          f_st = ST_NO_FRAME;
        end else begin
          f_we   = 1'b1;
          f_wa   = g;
          f_wd   = {req_page, PIN_BITS'(1), 1'b0, 1'b1};
          f_vset = 1'b1;
          f_fr   = g;
          if (req == REQ_FETCH) begin
            f_dc = DK_READ;
            f_dp = req_page;
          end
        end
      end
      REQ_UNPIN: begin
        if (!hit) begin
          f_st = ST_ABSENT;
        end else if (e_pins == '0) begin
          f_st = ST_NOT_PINNED;
          f_fr = f;
        end else begin
          f_we = 1'b1;
          f_wd[PIN_BITS+1:2] = e_pins - 1'b1;
          f_fr = f;
          if (mark && !e[1]) begin
            f_wd[1]  = 1'b1;
            tally_nx = tally + 1'b1;
          end
        end
      end
      REQ_FLUSH: begin
        if (hit) begin
          f_fr = f;
          if (e[1]) begin
            f_we     = 1'b1;
            f_wd[1]  = 1'b0;
            tally_nx = tally_dec;
            f_dc     = DK_WRITE;
            f_dp     = req_page;
          end
        end
      end
      REQ_DELETE: begin
        if (!hit) begin
          f_dc = DK_DEALLOC;
          f_dp = req_page;
        end else if (e_pins != '0) begin
          f_st = ST_PINNED;
          f_fr = f;
        end else begin
          f_vclr = 1'b1;
          f_push = (level < LW'(POOL_FRAMES));
          if (e[1]) tally_nx = tally_dec;
          f_fr = f;
          f_dc = DK_DEALLOC;
          f_dp = req_page;
        end
      end
      default: begin
      end
    endcase
  end

  // single write port of the frame table
  always_comb begin
    m_we = 1'b0;
    m_wa = f_wa;
    m_wd = f_wd;
    if (cmd == CMD_FINISH) begin
      m_we = f_we;
    end else if (sw_clr) begin
      m_we = 1'b1;
      m_wa = rd_idx;
      m_wd = {rd_data[EW-1:1], 1'b0};
    end
  end

  // frame table and free queue memories
  always_ff @(posedge clk) begin
    if (m_we) ent_mem[m_wa] <= m_wd;
    rd_data <= ent_mem[addr];
    rd_idx  <= addr;
    if (cmd == CMD_CLEAR) fq_mem[cnt[AW-1:0]] <= cnt[AW-1:0];
    else if (cmd == CMD_FINISH && f_push) fq_mem[push_slot] <= f;
    fq_rd <= fq_mem[head];
  end

  // request capture and per-item scratch registers
  always_ff @(posedge clk) begin
    if (cmd == CMD_LOAD) begin
      req      <= in_req;
      req_page <= in_page;
      mark     <= in_mark;
    end
    if (sc_hit) begin
      f <= rd_idx;
      e <= rd_data;
    end
    if (cmd == CMD_FQ_TAKE) g <= fq_rd;
    if (sw_take) begin
      g       <= rd_idx;
      wb      <= rd_data[1];
      wb_page <= rd_data[EW-1 -: PAGE_W];
    end else if (cmd == CMD_LOAD) begin
      wb <= 1'b0;
    end
  end

  // control state of the pool
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      head    <= '0;
      level   <= LW'(POOL_FRAMES);
      hand    <= '0;
      tally   <= '0;
      cnt     <= '0;
      addr    <= '0;
      rd_live <= 1'b0;
      hit     <= 1'b0;
      got     <= 1'b0;
    end else begin
      rd_live <= issue;
      if (issue) begin
        addr <= addr_inc;
        cnt  <= cnt + 1'b1;
      end else if (cmd == CMD_SCAN || cmd == CMD_SWEEP || cmd == CMD_CLEAR) begin
        cnt <= cnt + 1'b1;
      end
      if (sc_hit) hit <= 1'b1;
      unique case (cmd)
        CMD_LOAD: begin
          cnt  <= '0;
          addr <= '0;
          hit  <= 1'b0;
          got  <= 1'b0;
        end
        CMD_FQ_TAKE: begin
          got   <= 1'b1;
          head  <= head_inc;
          level <= level - 1'b1;
        end
        CMD_SWEEP_INIT: begin
          cnt  <= '0;
          addr <= hand;
        end
        CMD_FINISH: begin
          tally <= tally_nx;
          if (f_vset) valid[f_wa] <= 1'b1;
          if (f_vclr) valid[f]    <= 1'b0;
          if (f_push) level       <= level + 1'b1;
        end
        default: begin
        end
      endcase
      if (sw_take) begin
        got           <= 1'b1;
        valid[rd_idx] <= 1'b0;
        hand          <= (rd_idx == AW'(POOL_FRAMES - 1)) ? '0 : rd_idx + 1'b1;
        if (rd_data[1]) tally <= tally_dec;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
    end else if (cmd == CMD_EMIT_WB) begin
      out_tvalid <= 1'b1;
      out_last   <= 1'b0;
      out_status <= ST_OK;
      out_frame  <= g;
      out_cmd    <= DK_WRITE;
      out_page   <= wb_page;
      out_total  <= tally;
    end else if (cmd == CMD_FINISH) begin
      out_tvalid <= 1'b1;
      out_last   <= 1'b1;
      out_status <= f_st;
      out_frame  <= f_fr;
      out_cmd    <= f_dc;
      out_page   <= f_dp;
      out_total  <= tally_nx;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  // status toward the controller
  always_comb begin
    stat.clear_done = (cnt == CW'(POOL_FRAMES - 1));
    stat.scan_done  = (cnt == CW'(POOL_FRAMES + 1));
    stat.sweep_done = (cnt == CW'(SWEEP_PASSES * POOL_FRAMES + 1));
    stat.hit        = hit;
    stat.got        = got;
    stat.wb         = wb;
    stat.free_avail = (level != '0);
    stat.out_free   = !out_tvalid || out_tready;
    stat.is_alloc   = (req == REQ_FETCH) || (req == REQ_NEW);
  end

endmodule

[src/pbc_ctrl.sv]
// Controller state machine of the buffer pool: sequences lookup, free
// queue take, clock sweep and result delivery. Depends on pbc_pkg.
module pbc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  pbc_pkg::dp_stat_t stat,
  output pbc_pkg::dp_cmd_t  cmd
);
  import pbc_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    in_tready  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd = CMD_CLEAR;
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd        = CMD_LOAD;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) state_next = S_DECIDE;
        else                cmd = CMD_SCAN;
      end
      S_DECIDE: begin
        if (stat.is_alloc && !stat.hit)
          state_next = stat.free_avail ? S_FQ_TAKE : S_SWEEP_INIT;
        else
          state_next = S_FINISH;
      end
      S_FQ_TAKE: begin
        cmd        = CMD_FQ_TAKE;
        state_next = S_FINISH;
      end
      S_SWEEP_INIT: begin
        cmd        = CMD_SWEEP_INIT;
        state_next = S_SWEEP;
      end
      S_SWEEP: begin
        if (stat.got)             state_next = stat.wb ? S_EMIT_WB : S_FINISH;
        else if (stat.sweep_done) state_next = S_FINISH;
        else                      cmd = CMD_SWEEP;
      end
      S_EMIT_WB: begin
        if (stat.out_free) begin
          cmd        = CMD_EMIT_WB;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd        = CMD_FINISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[sim/testbench.sv]
// Self-checking testbench for the clock-replacement page buffer pool.
// Needs pbc_pkg and page_buffer_pool_clock_replacement; predicts each result in a class.
module testbench;
  import pbc_pkg::*;

  localparam int NF = 64;
  localparam int PIN_MAX = 255;
  localparam int OW = 56;

  typedef struct packed {
    st_t st;
    logic [5:0] frame;
    dk_t dk;
    logic [31:0] dpage;
    logic [6:0] dirty;
    logic last;
  } pool_result_t;

  int fail_count = 0;

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // Pool predictor and store of expected results
  class pool_scoreboard;
    logic [31:0] page[NF];
    bit valid[NF];
    int pins[NF];
    bit dirty[NF];
    bit refd[NF];
    int fq[NF];
    int fq_head, fq_level, hand, dirty_tally;
    pool_result_t pending[$];

    function void reset_state();
      for (int i = 0; i < NF; i++) begin
        page[i] = 0; valid[i] = 0; pins[i] = 0; dirty[i] = 0; refd[i] = 0; fq[i] = i;
      end
      fq_head = 0; fq_level = NF; hand = 0; dirty_tally = 0;
    endfunction

    function int lookup(logic [31:0] p);
      for (int i = 0; i < NF; i++)
        if (valid[i] && page[i] == p) return i;
      return -1;
    endfunction

    function void add(st_t s, int f, dk_t d, logic [31:0] p, bit l);
      pool_result_t r;
      r.st = s; r.frame = f[5:0]; r.dk = d; r.dpage = p; r.dirty = 0; r.last = l;
      pending = {pending, r};
    endfunction

    // Frame from free queue, else two-pass second-chance sweep
    function int grab(output bit wb, output logic [31:0] wbp);
      int idx;
      wb = 0; wbp = 0;
      if (fq_level > 0) begin
        idx = fq[fq_head];
        fq_head = (fq_head + 1) % NF;
        fq_level--;
        return idx;
      end
      for (int k = 0; k < 2 * NF; k++) begin
        idx = (hand + k) % NF;
        if (!valid[idx] || pins[idx] != 0) continue;
        if (refd[idx]) begin
          refd[idx] = 0;
          continue;
        end
        if (dirty[idx]) begin
          wb = 1; wbp = page[idx];
          if (dirty_tally > 0) dirty_tally--;
        end
        valid[idx] = 0; dirty[idx] = 0; refd[idx] = 0; pins[idx] = 0;
        hand = (idx + 1) % NF;
        return idx;
      end
      return -1;
    endfunction

    function void note_request(logic [2:0] rq, logic [31:0] p, bit mark);
      int f, g, first;
      bit wb;
      logic [31:0] wbp;
      first = pending.size();
      f = lookup(p);
      case (rq)
        REQ_FETCH, REQ_NEW: begin
          if (f >= 0) begin
            if (pins[f] < PIN_MAX) pins[f]++;
            refd[f] = 1;
            add(ST_OK, f, DK_NONE, 0, 1);
          end else begin
            g = grab(wb, wbp);
            if (g < 0) add(ST_NO_FRAME, 0, DK_NONE, 0, 1);
            else begin
              if (wb) add(ST_OK, g, DK_WRITE, wbp, 0);
              page[g] = p; valid[g] = 1; pins[g] = 1; dirty[g] = 0; refd[g] = 1;
              if (rq == REQ_FETCH) add(ST_OK, g, DK_READ, p, 1);
              else add(ST_OK, g, DK_NONE, 0, 1);
            end
          end
        end
        REQ_UNPIN: begin
          if (f < 0) add(ST_ABSENT, 0, DK_NONE, 0, 1);
          else if (pins[f] == 0) add(ST_NOT_PINNED, f, DK_NONE, 0, 1);
          else begin
            pins[f]--;
            if (mark && !dirty[f]) begin
              dirty[f] = 1; dirty_tally++;
            end
            add(ST_OK, f, DK_NONE, 0, 1);
          end
        end
        REQ_FLUSH: begin
          if (f < 0) add(ST_OK, 0, DK_NONE, 0, 1);
          else if (!dirty[f]) add(ST_OK, f, DK_NONE, 0, 1);
          else begin
            dirty[f] = 0;
            if (dirty_tally > 0) dirty_tally--;
            add(ST_OK, f, DK_WRITE, p, 1);
          end
        end
        REQ_DELETE: begin
          if (f < 0) add(ST_OK, 0, DK_DEALLOC, p, 1);
          else if (pins[f] != 0) add(ST_PINNED, f, DK_NONE, 0, 1);
          else begin
            if (dirty[f] && dirty_tally > 0) dirty_tally--;
            valid[f] = 0; dirty[f] = 0; refd[f] = 0; pins[f] = 0;
            if (fq_level < NF) begin
              fq[(fq_head + fq_level) % NF] = f;
              fq_level++;
            end
            add(ST_OK, f, DK_DEALLOC, p, 1);
          end
        end
        default: add(ST_OK, 0, DK_NONE, 0, 1);
      endcase
      for (int k = first; k < pending.size(); k++) pending[k].dirty = dirty_tally[6:0];
    endfunction

    task check_result(logic [OW-1:0] d, logic l);
      pool_result_t w;
      if (pending.size() == 0) begin
        report("unexpected result", d, 0);
        return;
      end
      w = pending[0];
      pending.delete(0);
      if (d[2:0] != w.st) report("status", d[2:0], w.st);
      if (d[8:3] != w.frame) report("frame_index", d[8:3], w.frame);
      if (d[10:9] != w.dk) report("disk_command", d[10:9], w.dk);
      if (d[42:11] != w.dpage) report("disk_page", d[42:11], w.dpage);
      if (d[49:43] != w.dirty) report("dirty_total", d[49:43], w.dirty);
      if (l != w.last) report("tlast", l, w.last);
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [39:0] s_axis_tdata = 0;
  logic m_axis_tvalid, m_axis_tready = 0, m_axis_tlast;
  logic [OW-1:0] m_axis_tdata;

  pool_scoreboard sb = new();
  bit hold_off = 0;
  bit bursty = 1;
  int cycles = 0;
  logic [31:0] pages_used[$];

  page_buffer_pool_clock_replacement dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: stall pattern plus long hold-off
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready && !rst) sb.check_result(m_axis_tdata, m_axis_tlast);
    if (rst || hold_off) m_axis_tready <= 0;
    else if (cycles % 64 < 20) m_axis_tready <= 1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  // Send one request transaction; keeps tvalid across back-to-back items
  task automatic send_request(logic [2:0] rq, logic [31:0] p, bit mark, bit keep);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {4'b0, mark, p, rq};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(rq, p, mark);
    if (!keep) s_axis_tvalid <= 0;
  endtask

  task automatic send_gap();
    int g;
    g = bursty ? $urandom_range(0, 4) : 0;
    if (g == 0) return;
    s_axis_tvalid <= 0;
    repeat (g) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_page();
    if (pages_used.size() > 0 && $urandom_range(0, 9) < 8)
      return pages_used[$urandom_range(0, pages_used.size() - 1)];
    pick_page = $urandom();
    pages_used = {pages_used, pick_page};
    if (pages_used.size() > 90) pages_used.delete(0);
  endfunction

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [2:0] rq;
    sb.reset_state();
    repeat (6) @(posedge clk);
    rst <= 0;
    // Directed: every request kind and the corner cases
    send_request(REQ_UNPIN, 32'h0, 0, 0);
    send_request(REQ_FLUSH, 32'hFFFF_FFFF, 0, 0);
    send_request(REQ_DELETE, 32'hFFFF_FFFF, 0, 0);
    send_request(REQ_FETCH, 32'h0, 0, 1);
    send_request(REQ_FETCH, 32'hFFFF_FFFF, 0, 1);
    send_request(REQ_NEW, 32'hFFFF_FFFF, 0, 1);
    send_request(REQ_NEW, 32'h5555_AAAA, 0, 1);
    send_request(REQ_DELETE, 32'h0, 0, 1);
    send_request(REQ_UNPIN, 32'h0, 1, 1);
    send_request(REQ_UNPIN, 32'h0, 0, 1);
    send_request(REQ_FLUSH, 32'h0, 0, 1);
    send_request(REQ_DELETE, 32'h5555_AAAA, 0, 1);
    send_request(3'd5, 32'h1234, 1, 1);
    send_request(3'd7, 32'hAAAA_5555, 0, 1);
    send_request(REQ_UNPIN, 32'hFFFF_FFFF, 1, 1);
    send_request(REQ_FLUSH, 32'hFFFF_FFFF, 0, 0);
    // Pin saturation on one page
    for (int i = 0; i < 258; i++) send_request(REQ_FETCH, 32'h0000_0077, 0, 1);
    send_request(REQ_UNPIN, 32'h0000_0077, 1, 0);
    // Pause until everything has come back
    drain();
    // Fill the pool so the sweep and dirty write backs happen
    for (int i = 0; i < 64; i++) begin
      send_request(REQ_NEW, 32'h1000 + i, 0, 1);
      send_request(REQ_UNPIN, 32'h1000 + i, i[0], 1);
    end
    send_gap();
    // Long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 20; i++) send_request(REQ_FETCH, $urandom(), 0, 1);
    join
    // Random mix, mostly over a working set
    for (int n = 0; n < 80; n++) begin
      if (n % 40 == 20) bursty = !bursty;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: rq = REQ_FETCH;
        4: rq = REQ_NEW;
        5, 6: rq = REQ_UNPIN;
        7: rq = REQ_FLUSH;
        8: rq = REQ_DELETE;
        default: rq = 3'($urandom_range(0, 7));
      endcase
      send_request(rq, pick_page(), 1'($urandom_range(0, 1)), 1);
      send_gap();
    end
    drain();
    repeat (400) @(posedge clk);
    if (fail_count == 0 && sb.pending.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
